[src/evrg_pkg.sv]
`timescale 1ns / 1ps
// Package for the eased value ramp generator: field widths, item mode codes,
// the quarter-sine table builder and the saturation helper. No dependencies.

package evrg_pkg;

    localparam int VALUE_W         = 32;
    localparam int DELTA_W         = VALUE_W + 1;
    localparam int DUR_W           = 16;
    localparam int DUR_IN_W        = 16;
    localparam int FRAC_W          = 16;
    localparam int PHASE_W         = FRAC_W + 1;
    localparam int SINE_TABLE_SIZE = 256;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);
    localparam int SUM_W           = VALUE_W + 4;
    localparam int ACC_HI_W        = DELTA_W + 2;
    localparam int ACC_W           = ACC_HI_W + PHASE_W;
    localparam int CNT_W           = $clog2(PHASE_W);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_SHIFT = 2'd2;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [63:0] PHASE_ONE = 64'd1 << FRAC_W;

    // One entry of the ease-out table: sin(i * pi / (2 * size)) in Q.16,
    // built from a truncated Taylor series in Q30. Only ever called with
    // constant arguments. The table size is a power of two, so the angle
    // step is a plain shift.
    function automatic logic [PHASE_W-1:0] sine_entry(input int idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] e;
        longint      s;
        x    = (64'(idx) * PI_Q30) >> (SINE_IDX_W + 1);
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        s    = s + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        s    = s - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        s    = s + longint'(term);
        if (s < 0) begin
            s = 0;
        end
        e = (64'(s) + 64'd8192) >> 14;
        if (e > PHASE_ONE) begin
            e = PHASE_ONE;
        end
        return PHASE_W'(e);
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-VALUE_W:0] top;
        top = v[SUM_W-1:VALUE_W-1];
        if ((&top) || !(|top)) begin
            return v[VALUE_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
    endfunction

endpackage

[src/eased_value_ramp_generator.sv]
`timescale 1ns / 1ps
// Top level of the eased value ramp generator: state update, bit-serial phase
// divider, bit-serial multiplier and output register. Depends on evrg_pkg.
//
//  Channel   Direction  Handshake            Word
//  s_        in         s_valid / s_ready    s_mode, s_value, s_duration_ticks
//  m_        out        m_valid / m_ready    m_current_value, m_target_value,
//                                            m_animating, m_finished
//  cfg_      in         cfg_we (no wait)     cfg_wdata (motion_mode)
//
// A word that needs the curve passes through update, setup, the restoring
// divider (one quotient bit a cycle), table lookup, the shift-add multiplier
// (one phase bit a cycle), sum and output load; a set that restarts a running
// ramp also passes through the set step. A word with the ramp at rest skips
// the divider and the multiplier. One word is in work at a
// time; s_ready is high only between words, and a finished result waits in
// the output register while the next word is taken. Reset is synchronous and
// clears the ramp state to zero, not animating, with the ease-out curve chosen.

module eased_value_ramp_generator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic                                   cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_mode,
    input  logic signed [evrg_pkg::VALUE_W-1:0]    s_value,
    input  logic [evrg_pkg::DUR_IN_W-1:0]          s_duration_ticks,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [evrg_pkg::VALUE_W-1:0]    m_current_value,
    output logic signed [evrg_pkg::VALUE_W-1:0]    m_target_value,
    output logic                                   m_animating,
    output logic                                   m_finished
);

    localparam int VW = evrg_pkg::VALUE_W;
    localparam int DW = evrg_pkg::DELTA_W;
    localparam int TW = evrg_pkg::DUR_W;
    localparam int FW = evrg_pkg::FRAC_W;
    localparam int PW = evrg_pkg::PHASE_W;
    localparam int SW = evrg_pkg::SUM_W;
    localparam int HW = evrg_pkg::ACC_HI_W;
    localparam int AW = evrg_pkg::ACC_W;
    localparam int CW = evrg_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_UPDATE = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_PHASE  = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_SUM    = 4'd6;
    localparam logic [3:0] ST_SET    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam logic [HW-1:0] ROUND_HALF = HW'(1) << (FW - 1);

    logic [3:0]              state_reg, state_next;
    logic                    motion_mode_reg;

    logic [1:0]              in_mode_reg, in_mode_next;
    logic signed [VW-1:0]    in_value_reg, in_value_next;
    logic [TW-1:0]           in_dur_reg, in_dur_next;

    logic signed [VW-1:0]    start_reg, start_next;
    logic signed [DW-1:0]    delta_reg, delta_next;
    logic [TW-1:0]           elapsed_reg, elapsed_next;
    logic [TW-1:0]           total_reg, total_next;
    logic                    busy_reg, busy_next;
    logic                    fin_reg, fin_next;
    logic                    set_pend_reg, set_pend_next;

    logic [TW-1:0]           rem_reg, rem_next;
    logic [FW-1:0]           quo_reg, quo_next;
    logic [PW-1:0]           phase_reg, phase_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic signed [VW-1:0]    cur_reg, cur_next;

    logic                    m_valid_reg, m_valid_next;
    logic signed [VW-1:0]    m_cur_reg, m_cur_next;
    logic signed [VW-1:0]    m_tgt_reg, m_tgt_next;
    logic                    m_anim_reg, m_anim_next;
    logic                    m_fin_reg, m_fin_next;

    logic [PW-1:0]           sine_rom [evrg_pkg::SINE_TABLE_SIZE];

    logic signed [SW-1:0]    sum_sd;
    logic signed [SW-1:0]    sum_sv;
    logic signed [SW-1:0]    sum_sq;
    logic [TW-1:0]           elapsed_inc;
    logic [TW:0]             div_r2;
    logic                    div_ge;
    logic signed [HW-1:0]    mul_hi;
    logic [evrg_pkg::SINE_IDX_W-1:0] sine_idx;

    for (genvar g = 0; g < evrg_pkg::SINE_TABLE_SIZE; g++) begin : g_sine
        assign sine_rom[g] = evrg_pkg::sine_entry(g);
    end

    assign sum_sd      = SW'(start_reg) + SW'(delta_reg);
    assign sum_sv      = SW'(start_reg) + SW'(in_value_reg);
    assign sum_sq      = SW'(start_reg) + SW'(acc_reg[AW-1:FW]);
    assign elapsed_inc = elapsed_reg + TW'(1);
    assign div_r2      = {rem_reg, 1'b0};
    assign div_ge      = div_r2 >= {1'b0, total_reg};
    assign mul_hi      = acc_reg[AW-1:PW] + (phase_reg[0] ? HW'(delta_reg) : HW'(0));
    assign sine_idx    = quo_reg[FW-1 -: evrg_pkg::SINE_IDX_W];

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_current_value = m_cur_reg;
    assign m_target_value  = m_tgt_reg;
    assign m_animating     = m_anim_reg;
    assign m_finished      = m_fin_reg;

    always_comb begin
        state_next    = state_reg;
        in_mode_next  = in_mode_reg;
        in_value_next = in_value_reg;
        in_dur_next   = in_dur_reg;
        start_next    = start_reg;
        delta_next    = delta_reg;
        elapsed_next  = elapsed_reg;
        total_next    = total_reg;
        busy_next     = busy_reg;
        fin_next      = fin_reg;
        set_pend_next = set_pend_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_cur_next    = m_cur_reg;
        m_tgt_next    = m_tgt_reg;
        m_anim_next   = m_anim_reg;
        m_fin_next    = m_fin_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_mode_next  = s_mode;
                    in_value_next = s_value;
                    in_dur_next   = s_duration_ticks[TW-1:0];
                    fin_next      = 1'b0;
                    set_pend_next = 1'b0;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                case (in_mode_reg)
                    evrg_pkg::MODE_TICK: begin
                        if (busy_reg) begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc >= total_reg) begin
                                start_next = evrg_pkg::sat32(sum_sd);
                                delta_next = '0;
                                busy_next  = 1'b0;
                                fin_next   = 1'b1;
                            end
                        end
                    end
                    evrg_pkg::MODE_SET: begin
                        // A ramp restarts from the value shown before the set, so
                        // the update waits until that value has been worked out.
                        if (in_dur_reg != '0) begin
                            set_pend_next = 1'b1;
                        end else begin
                            start_next   = in_value_reg;
                            delta_next   = '0;
                            elapsed_next = '0;
                            total_next   = '0;
                            busy_next    = 1'b0;
                        end
                    end
                    evrg_pkg::MODE_SHIFT: begin
                        start_next = evrg_pkg::sat32(sum_sv);
                    end
                    default: begin
                    end
                endcase
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (busy_reg && (total_reg != '0) && (elapsed_reg < total_reg)) begin
                    rem_next   = elapsed_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cur_next   = start_reg;
                    state_next = set_pend_reg ? ST_SET : ST_OUT;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? TW'(div_r2 - {1'b0, total_reg}) : div_r2[TW-1:0];
                quo_next = {quo_reg[FW-2:0], div_ge};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FW - 1)) begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                phase_next = motion_mode_reg ? sine_rom[sine_idx] : {1'b0, quo_reg};
                // The rounding half is preloaded so it lands at weight 2^15
                // after the seventeen right shifts.
                acc_next   = {ROUND_HALF, {PW{1'b0}}};
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = {mul_hi[HW-1], mul_hi, acc_reg[PW-1:1]};
                phase_next = phase_reg >> 1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PW - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cur_next   = evrg_pkg::sat32(sum_sq);
                state_next = set_pend_reg ? ST_SET : ST_OUT;
            end
            ST_SET: begin
                // The new ramp starts at phase zero, so the shown value is the
                // new start and needs no second pass.
                start_next   = cur_reg;
                delta_next   = DW'(in_value_reg) - DW'(cur_reg);
                elapsed_next = '0;
                total_next   = in_dur_reg;
                busy_next    = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cur_next   = cur_reg;
                    m_tgt_next   = evrg_pkg::sat32(sum_sd);
                    m_anim_next  = busy_reg;
                    m_fin_next   = fin_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            motion_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= '0;
            delta_reg    <= '0;
            elapsed_reg  <= '0;
            total_reg    <= '0;
            busy_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            set_pend_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            delta_reg    <= delta_next;
            elapsed_reg  <= elapsed_next;
            total_reg    <= total_next;
            busy_reg     <= busy_next;
            fin_reg      <= fin_next;
            set_pend_reg <= set_pend_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_mode_reg  <= in_mode_next;
        in_value_reg <= in_value_next;
        in_dur_reg   <= in_dur_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        phase_reg    <= phase_next;
        acc_reg      <= acc_next;
        cur_reg      <= cur_next;
        m_cur_reg    <= m_cur_next;
        m_tgt_reg    <= m_tgt_next;
        m_anim_reg   <= m_anim_next;
        m_fin_reg    <= m_fin_next;
    end

    // At rest the pending delta is always folded away.
    a_rest_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (delta_reg == '0))
        else $error("delta left pending while not animating");

    // A running ramp has a nonzero length and has not yet reached it.
    a_busy_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ((total_reg != '0) && (elapsed_reg < total_reg)))
        else $error("running ramp outside its length");

    // A word that reports completion never reports a ramp still running.
    a_fin_not_anim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fin_reg) |-> !m_anim_reg)
        else $error("finished and animating in the same word");

    // The input side only opens once the previous result has been loaded.
    a_ready_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT) && (state_next == ST_IDLE)) |=> m_valid_reg)
        else $error("result lost on the way to the output register");

endmodule
